### design/tbpg_pkg.sv
// Package for the two-button press gesture decoder.
// Holds the shared types, constants and the hold-time compare function.
// No dependencies.
package tbpg_pkg;

  // Width of the tick counter that elapsed time wraps at.
  localparam int unsigned TimeBits = 32;
  localparam int unsigned TicksBits = 32;
  localparam int unsigned CmpBits = (TimeBits > TicksBits) ? TimeBits : TicksBits;

  localparam logic [TicksBits-1:0] LongPressReset = 32'd1000000;

  typedef logic [TimeBits-1:0] time_t;

  // Button pattern, left in bit 1 and right in bit 0.
  typedef enum logic [1:0] {
    PatNone  = 2'b00,
    PatRight = 2'b01,
    PatLeft  = 2'b10,
    PatBoth  = 2'b11
  } btn_pat_e;

  typedef struct packed {
    logic  left_was_pressed;
    logic  right_was_pressed;
    time_t left_press_start;
    time_t right_press_start;
    logic  left_long_done;
    logic  right_long_done;
  } state_t;

  typedef struct packed {
    logic left_long_event;
    logic right_long_plain;
    logic right_long_modified;
    logic left_tap_trigger;
    logic right_tap_trigger;
    logic left_toggle;
    logic right_toggle;
  } result_t;

  // True when the wrapped elapsed time reaches the threshold.
  function automatic logic held_long_enough(time_t now, time_t start,
                                            logic [TicksBits-1:0] thr);
    time_t              elapsed;
    logic [CmpBits-1:0] elapsed_w;
    logic [CmpBits-1:0] thr_w;
    elapsed   = now - start;
    elapsed_w = CmpBits'(elapsed);
    thr_w     = CmpBits'(thr);
    return elapsed_w >= thr_w;
  endfunction

endpackage

### design/tbpg_step.sv
// Combinational step of the gesture decoder: next state and result flags.
// Depends on tbpg_pkg.
module tbpg_step (
  input  logic                             left_pressed_i,
  input  logic                             right_pressed_i,
  input  logic                             pedal_held_i,
  input  tbpg_pkg::time_t                  now_i,
  input  logic [tbpg_pkg::TicksBits-1:0]   long_press_ticks_i,
  input  tbpg_pkg::state_t                 state_i,
  output tbpg_pkg::state_t                 state_o,
  output tbpg_pkg::result_t                result_o
);

  tbpg_pkg::btn_pat_e prev_pat;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    prev_pat = tbpg_pkg::btn_pat_e'({state_i.left_was_pressed, state_i.right_was_pressed});

    // A rising edge starts a new hold.
    if (left_pressed_i && !state_i.left_was_pressed) begin
      state_o.left_press_start = now_i;
      state_o.left_long_done   = 1'b0;
    end
    if (right_pressed_i && !state_i.right_was_pressed) begin
      state_o.right_press_start = now_i;
      state_o.right_long_done   = 1'b0;
    end

    // Long press fires once per hold.
    if (left_pressed_i && !state_o.left_long_done &&
        tbpg_pkg::held_long_enough(now_i, state_o.left_press_start, long_press_ticks_i)) begin
      result_o.left_long_event = 1'b1;
      state_o.left_long_done   = 1'b1;
    end
    if (right_pressed_i && !state_o.right_long_done &&
        tbpg_pkg::held_long_enough(now_i, state_o.right_press_start, long_press_ticks_i)) begin
      result_o.right_long_modified = pedal_held_i;
      result_o.right_long_plain    = !pedal_held_i;
      state_o.right_long_done      = 1'b1;
    end

    // Full release decides on the previous pattern.
    if (!left_pressed_i && !right_pressed_i) begin
      unique case (prev_pat)
        tbpg_pkg::PatNone: begin
        end
        tbpg_pkg::PatRight: begin
          if (!state_o.right_long_done) begin
            result_o.right_tap_trigger = pedal_held_i;
            result_o.right_toggle      = !pedal_held_i;
          end
          state_o.right_long_done = 1'b0;
        end
        tbpg_pkg::PatLeft: begin
          if (!state_o.left_long_done) begin
            result_o.left_tap_trigger = pedal_held_i;
            result_o.left_toggle      = !pedal_held_i;
          end
          state_o.left_long_done = 1'b0;
        end
        default: begin
          if (!state_o.left_long_done && !state_o.right_long_done) begin
            result_o.left_toggle  = 1'b1;
            result_o.right_toggle = 1'b1;
          end
          state_o.left_long_done  = 1'b0;
          state_o.right_long_done = 1'b0;
        end
      endcase
    end

    state_o.left_was_pressed  = left_pressed_i;
    state_o.right_was_pressed = right_pressed_i;
  end

endmodule

### design/tbpg_out_buf.sv
// Output register with a skid stage for the gesture decoder results.
// Depends on tbpg_pkg.
module tbpg_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tbpg_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tbpg_pkg::result_t out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tbpg_pkg::result_t out_data_q, out_data_d;
  tbpg_pkg::result_t skid_data_q, skid_data_d;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### design/two_button_press_gesture_decoder_unit.sv
// Top level of the two-button press gesture decoder.
// Depends on tbpg_pkg, tbpg_step and tbpg_out_buf.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-------------------------------------------
//   input   | in_valid_i / in_stall_o | left_pressed_i, right_pressed_i,
//           |                         | pedal_held_i, now_ticks_i
//   output  | out_valid_o/out_stall_i | seven result flags
//   config  | cfg_we_i                | cfg_wdata_i (long_press_ticks)
//
// Each sample's result is registered in the output register behind the
// subtract-and-compare logic, or in the skid stage while the output is stalled;
// a new sample can be accepted every cycle while in_stall_o is low.
// Reset clears the button history, the long-press flags and both buffer slots,
// and loads the threshold with its default of one million ticks.
// When the output is stalled, one more result is held in a skid stage, after
// which in_stall_o goes high until the output drains.
module two_button_press_gesture_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        left_pressed_i,
  input  logic        right_pressed_i,
  input  logic        pedal_held_i,
  input  logic [31:0] now_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        left_long_event_o,
  output logic        right_long_plain_o,
  output logic        right_long_modified_o,
  output logic        left_tap_trigger_o,
  output logic        right_tap_trigger_o,
  output logic        left_toggle_o,
  output logic        right_toggle_o
);

  logic [tbpg_pkg::TicksBits-1:0] long_press_ticks_q;
  tbpg_pkg::state_t               state_q, state_d;
  tbpg_pkg::result_t              step_result;
  tbpg_pkg::result_t              out_result;
  tbpg_pkg::time_t                now;
  logic                           buf_full;
  logic                           in_xfer;

  // A transfer on the input side happens whenever in_valid_i is high and the skid stage is empty.
  assign in_stall_o = buf_full;
  assign in_xfer    = in_valid_i && !buf_full;
  assign now        = tbpg_pkg::TimeBits'(now_ticks_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ticks_q <= tbpg_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      long_press_ticks_q <= cfg_wdata_i;
    end
  end

  tbpg_step u_step (
    .left_pressed_i     (left_pressed_i),
    .right_pressed_i    (right_pressed_i),
    .pedal_held_i       (pedal_held_i),
    .now_i              (now),
    .long_press_ticks_i (long_press_ticks_q),
    .state_i            (state_q),
    .state_o            (state_d),
    .result_o           (step_result)
  );

  // Decoder state advances only on an input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  tbpg_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .data_i      (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_result)
  );

  assign left_long_event_o     = out_result.left_long_event;
  assign right_long_plain_o    = out_result.right_long_plain;
  assign right_long_modified_o = out_result.right_long_modified;
  assign left_tap_trigger_o    = out_result.left_tap_trigger;
  assign right_tap_trigger_o   = out_result.right_tap_trigger;
  assign left_toggle_o         = out_result.left_toggle;
  assign right_toggle_o        = out_result.right_toggle;

endmodule

### tb/sv/two_button_press_gesture_decoder_unit_tb.sv
// Testbench for two_button_press_gesture_decoder_unit: a table of directed samples, then
// random gesture phases at several hold thresholds, the phases checked against an in-bench decoder.
// Depends on tbpg_pkg and the design sources.
module two_button_press_gesture_decoder_unit_tb;

  localparam int HalfPeriod = 6;
  localparam int QuietLimit = 2000;
  localparam int LongHold = 60;
  localparam int NumDir = 27;
  localparam int NumPhases = 8;
  localparam int PhaseSamples = 80;

  typedef enum logic {
    RowSample,
    RowConfig
  } row_kind_e;

  // One directed step: either a sample or a threshold write (val holds ticks or the value).
  typedef struct packed {
    row_kind_e         kind;
    logic              lp;
    logic              rp;
    logic              pedal;
    logic [31:0]       val;
    logic              typed;
    tbpg_pkg::result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        left_pressed_i;
  logic        right_pressed_i;
  logic        pedal_held_i;
  logic [31:0] now_ticks_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        left_long_event_o;
  logic        right_long_plain_o;
  logic        right_long_modified_o;
  logic        left_tap_trigger_o;
  logic        right_tap_trigger_o;
  logic        left_toggle_o;
  logic        right_toggle_o;

  // Decoder state kept by the bench, mirroring the block's history and flags.
  logic            l_prev;
  logic            r_prev;
  tbpg_pkg::time_t l_start;
  tbpg_pkg::time_t r_start;
  logic            l_fired;
  logic            r_fired;
  logic [31:0]     hold_thr;

  tbpg_pkg::result_t flag_q[$];
  logic [31:0]       tick_now;
  int                errors;
  int                samples_sent;
  bit                idling_on;
  bit                hold_req;

  string flag_names [7] = '{"left_long_event", "right_long_plain", "right_long_modified",
                            "left_tap_trigger", "right_tap_trigger", "left_toggle",
                            "right_toggle"};

  // Directed steps. Result bits run from left_long_event down to right_toggle.
  dir_row_t dir_rows [NumDir] = '{
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'd0,          1'b1, 7'b0000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd5,          1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'd9,          1'b1, 7'b0000010},
    '{RowSample, 1'b0, 1'b1, 1'b1, 32'd20,         1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b1, 32'd30,         1'b1, 7'b0000100},
    '{RowSample, 1'b1, 1'b0, 1'b1, 32'd40,         1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b1, 32'd50,         1'b1, 7'b0001000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd100,        1'b1, 7'b0000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd1000100,    1'b1, 7'b1000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd3000000,    1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'd3000001,    1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b1, 1'b0, 32'hFFFFFFFF,   1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b1, 1'b0, 32'h000F423E,   1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b1, 1'b0, 32'h000F423F,   1'b1, 7'b0100000},
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'h000F4300,   1'b1, 7'b0000000},
    '{RowSample, 1'b1, 1'b1, 1'b0, 32'd200,        1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b1, 32'd400,        1'b1, 7'b0000011},
    '{RowSample, 1'b1, 1'b1, 1'b0, 32'd500,        1'b1, 7'b0000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd600,        1'b1, 7'b0000000},
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'd700,        1'b1, 7'b0000010},
    '{RowConfig, 1'b0, 1'b0, 1'b0, 32'd0,          1'b0, 7'b0000000},
    '{RowSample, 1'b0, 1'b1, 1'b1, 32'd800,        1'b1, 7'b0010000},
    '{RowSample, 1'b1, 1'b1, 1'b0, 32'd801,        1'b1, 7'b1000000},
    '{RowSample, 1'b0, 1'b0, 1'b0, 32'd802,        1'b1, 7'b0000000},
    '{RowConfig, 1'b0, 1'b0, 1'b0, 32'hFFFFFFFF,   1'b0, 7'b0000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'd0,          1'b1, 7'b0000000},
    '{RowSample, 1'b1, 1'b0, 1'b0, 32'hFFFFFFFF,   1'b1, 7'b1000000}
  };

  two_button_press_gesture_decoder_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .left_pressed_i        (left_pressed_i),
    .right_pressed_i       (right_pressed_i),
    .pedal_held_i          (pedal_held_i),
    .now_ticks_i           (now_ticks_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .left_long_event_o     (left_long_event_o),
    .right_long_plain_o    (right_long_plain_o),
    .right_long_modified_o (right_long_modified_o),
    .left_tap_trigger_o    (left_tap_trigger_o),
    .right_tap_trigger_o   (right_tap_trigger_o),
    .left_toggle_o         (left_toggle_o),
    .right_toggle_o        (right_toggle_o)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Decodes one sample and advances the bench's copy of the button history.
  function automatic tbpg_pkg::result_t decode_gesture(logic lp, logic rp, logic pedal,
                                                       tbpg_pkg::time_t now);
    tbpg_pkg::result_t  res;
    tbpg_pkg::btn_pat_e cur;
    tbpg_pkg::btn_pat_e prev;
    tbpg_pkg::time_t    l_elapsed;
    tbpg_pkg::time_t    r_elapsed;
    res = '0;
    cur = tbpg_pkg::btn_pat_e'({lp, rp});
    prev = tbpg_pkg::btn_pat_e'({l_prev, r_prev});
    // A rising edge restarts the hold and rearms the long press for that button.
    if (lp && !l_prev) begin
      l_start = now;
      l_fired = 1'b0;
    end
    if (rp && !r_prev) begin
      r_start = now;
      r_fired = 1'b0;
    end
    // Elapsed time wraps with the tick counter.
    l_elapsed = now - l_start;
    r_elapsed = now - r_start;
    if (lp && !l_fired && l_elapsed >= hold_thr) begin
      res.left_long_event = 1'b1;
      l_fired = 1'b1;
    end
    if (rp && !r_fired && r_elapsed >= hold_thr) begin
      if (pedal) begin
        res.right_long_modified = 1'b1;
      end else begin
        res.right_long_plain = 1'b1;
      end
      r_fired = 1'b1;
    end
    // Only the change to nothing pressed decides a tap or toggle; only the buttons that
    // were down have their flags cleared, so a stale flag can survive a pattern change.
    if (cur == tbpg_pkg::PatNone && prev != tbpg_pkg::PatNone) begin
      case (prev)
        tbpg_pkg::PatRight: begin
          if (!r_fired) begin
            if (pedal) begin
              res.right_tap_trigger = 1'b1;
            end else begin
              res.right_toggle = 1'b1;
            end
          end
          r_fired = 1'b0;
        end
        tbpg_pkg::PatLeft: begin
          if (!l_fired) begin
            if (pedal) begin
              res.left_tap_trigger = 1'b1;
            end else begin
              res.left_toggle = 1'b1;
            end
          end
          l_fired = 1'b0;
        end
        default: begin
          // Both released together: the pedal does not matter.
          if (!l_fired && !r_fired) begin
            res.left_toggle = 1'b1;
            res.right_toggle = 1'b1;
          end
          l_fired = 1'b0;
          r_fired = 1'b0;
        end
      endcase
    end
    l_prev = lp;
    r_prev = rp;
    return res;
  endfunction

  // Moves the sample clock forward. Steps landing exactly on and just short of the
  // threshold are favored so that long presses meet their boundary.
  function automatic logic [31:0] advance_ticks();
    logic [31:0] span;
    span = (hold_thr > 32'h00100000) ? 32'h00100000 : hold_thr + 32'd2;
    case ($urandom_range(0, 5))
      0: tick_now = tick_now + hold_thr;
      1: tick_now = tick_now + hold_thr - 32'd1;
      default: tick_now = tick_now + $urandom_range(0, span);
    endcase
    return tick_now;
  endfunction

  // Offers one sample until the transfer happens, then queues what it should produce.
  // A typed expectation from the directed table takes the place of the decoder's.
  task automatic offer_sample(input logic lp, input logic rp, input logic pedal,
                              input logic [31:0] ticks, input logic typed,
                              input tbpg_pkg::result_t want);
    tbpg_pkg::result_t pred;
    tbpg_pkg::result_t exp_res;
    pred = decode_gesture(lp, rp, pedal, ticks);
    exp_res = typed ? want : pred;
    in_valid_i <= 1'b1;
    left_pressed_i <= lp;
    right_pressed_i <= rp;
    pedal_held_i <= pedal;
    now_ticks_i <= ticks;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    flag_q.insert(flag_q.size(), exp_res);
    samples_sent++;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Lets the block drain completely, then loads a new hold threshold.
  task automatic write_hold_ticks(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (flag_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hold_thr = value;
  endtask

  // A press, a hold of a few samples with the odd pattern or pedal change, and a release.
  task automatic play_gesture();
    tbpg_pkg::btn_pat_e pat;
    logic               pedal;
    int                 hold_n;
    int                 k;
    pat = tbpg_pkg::btn_pat_e'($urandom_range(1, 3));
    pedal = 1'($urandom_range(0, 1));
    hold_n = $urandom_range(1, 5);
    for (k = 0; k < hold_n; k++) begin
      if ($urandom_range(0, 7) == 0) pedal = ~pedal;
      if ($urandom_range(0, 5) == 0) pat = tbpg_pkg::btn_pat_e'($urandom_range(1, 3));
      offer_sample(pat[1], pat[0], pedal, advance_ticks(), 1'b0, '0);
    end
    if ($urandom_range(0, 3) == 0) pedal = ~pedal;
    offer_sample(1'b0, 1'b0, pedal, advance_ticks(), 1'b0, '0);
  endtask

  // Stimulus: reset, the directed table, then one random phase per threshold.
  initial begin : stimulus
    logic [31:0] phase_thr [NumPhases];
    logic [31:0] noise_ticks;
    int          i;
    int          ph;
    int          phase_start;
    bit          hold_done;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    left_pressed_i = 1'b0;
    right_pressed_i = 1'b0;
    pedal_held_i = 1'b0;
    now_ticks_i = '0;
    idling_on = 1'b1;
    hold_req = 1'b0;
    errors = 0;
    samples_sent = 0;
    tick_now = '0;
    l_prev = 1'b0;
    r_prev = 1'b0;
    l_start = '0;
    r_start = '0;
    l_fired = 1'b0;
    r_fired = 1'b0;
    hold_thr = tbpg_pkg::LongPressReset;
    phase_thr = '{32'd1000000, 32'd0, 32'd1, 32'd7, 32'hFFFFFFFF, 32'd40, 32'd0, 32'd20};
    phase_thr[6] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDir; i++) begin
      if (dir_rows[i].kind == RowConfig) begin
        write_hold_ticks(dir_rows[i].val);
      end else begin
        offer_sample(dir_rows[i].lp, dir_rows[i].rp, dir_rows[i].pedal, dir_rows[i].val,
                     dir_rows[i].typed, dir_rows[i].want);
      end
    end

    hold_done = 1'b0;
    for (ph = 0; ph < NumPhases; ph++) begin
      write_hold_ticks(phase_thr[ph]);
      // The last phase runs with no idling on either side; phase three starts near wrap.
      idling_on = (ph != NumPhases - 1);
      if (ph == 3) tick_now = 32'hFFFFFF00;
      phase_start = samples_sent;
      while (samples_sent - phase_start < PhaseSamples) begin
        // Once, the receiver holds off for a long stretch while samples keep coming.
        if (ph == 1 && !hold_done && samples_sent - phase_start >= 20) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          noise_ticks = $urandom;
          if ($urandom_range(0, 1) == 0) tick_now = noise_ticks;
          offer_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), noise_ticks, 1'b0, '0);
        end else begin
          play_gesture();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (flag_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && flag_q.size() == 0) begin
      $display("two_button_press_gesture_decoder_unit: match");
    end else begin
      $display("two_button_press_gesture_decoder_unit: mismatch");
    end
    $finish;
  end

  // Output side stall: short random bursts, plus one long hold-off on request.
  initial begin : receiver
    int burst;
    int hold;
    out_stall_i = 1'b0;
    burst = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold = LongHold;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every result transfer is compared flag by flag with the oldest queued expectation.
  always @(posedge clk_i) begin : result_check
    tbpg_pkg::result_t got;
    tbpg_pkg::result_t want;
    int                k;
    if (out_valid_o && !out_stall_i) begin
      got = {left_long_event_o, right_long_plain_o, right_long_modified_o,
             left_tap_trigger_o, right_tap_trigger_o, left_toggle_o, right_toggle_o};
      if (flag_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        errors++;
      end else begin
        want = flag_q.pop_front();
        for (k = 0; k < 7; k++) begin
          if (got[6-k] !== want[6-k]) begin
            $display("%0t: %s expected %b actual %b", $time, flag_names[k],
                     want[6-k], got[6-k]);
            errors++;
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
    $display("two_button_press_gesture_decoder_unit: mismatch");
    $finish;
  end

endmodule
